### design/kalman_cv_tracker_2d_core_defines.svh
// ----------------------------------------------------------------------------
// Kalman tracker assertion macros
// Shared property forms for the checker of the tracker core.
// ----------------------------------------------------------------------------
`ifndef KALMAN_CV_TRACKER_2D_CORE_DEFINES_SVH
`define KALMAN_CV_TRACKER_2D_CORE_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define KCV_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kcv: next-cycle check failed");

// Consequent must hold in the cycle after the antecedent, reset included.
`define KCV_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("kcv: reset check failed");

`endif

### design/kcv_pkg.sv
// ----------------------------------------------------------------------------
// Kalman tracker package
// Types, register indexes, sequencer program and fixed-point helpers.
// ----------------------------------------------------------------------------
package kcv_pkg;

   localparam int QW = 48;

   typedef struct packed {
      logic signed [15:0] meas_x;
      logic signed [15:0] meas_y;
   } kcv_req_type;

   typedef struct packed {
      logic signed [15:0] est_x;
      logic signed [15:0] est_y;
   } kcv_rsp_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } kcv_op_type;

   typedef struct packed {
      logic              start;
      kcv_op_type        op;
      logic signed [47:0] a;
      logic signed [47:0] b;
   } kcv_alu_cmd_type;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_STEP_COEFF    = 3'd0;
   localparam logic [2:0] REG_PROCESS_NOISE = 3'd1;
   localparam logic [2:0] REG_MEASURE_NOISE = 3'd2;
   localparam logic [2:0] REG_START_X       = 3'd3;
   localparam logic [2:0] REG_START_Y       = 3'd4;

   // Operand codes: the low half addresses a slot of the axis bank,
   // the upper half selects a constant or input source.
   localparam logic [4:0] SRC_P    = 5'd0;
   localparam logic [4:0] SRC_V    = 5'd1;
   localparam logic [4:0] SRC_C0   = 5'd2;
   localparam logic [4:0] SRC_C1   = 5'd3;
   localparam logic [4:0] SRC_C2   = 5'd4;
   localparam logic [4:0] SRC_C3   = 5'd5;
   localparam logic [4:0] SRC_T0   = 5'd6;
   localparam logic [4:0] SRC_T1   = 5'd7;
   localparam logic [4:0] SRC_T2   = 5'd8;
   localparam logic [4:0] SRC_T3   = 5'd9;
   localparam logic [4:0] SRC_T4   = 5'd10;
   localparam logic [4:0] SRC_T5   = 5'd11;
   localparam logic [4:0] SRC_T6   = 5'd12;
   localparam logic [4:0] SRC_T7   = 5'd13;
   localparam logic [4:0] SRC_T8   = 5'd14;
   localparam logic [4:0] SRC_T9   = 5'd15;
   localparam logic [4:0] SRC_A    = 5'd16;
   localparam logic [4:0] SRC_Q    = 5'd17;
   localparam logic [4:0] SRC_R    = 5'd18;
   localparam logic [4:0] SRC_ONE  = 5'd19;
   localparam logic [4:0] SRC_MEAS = 5'd20;

   localparam logic [3:0] SLOT_P  = 4'd0;
   localparam logic [3:0] SLOT_V  = 4'd1;
   localparam logic [3:0] SLOT_C0 = 4'd2;
   localparam logic [3:0] SLOT_C1 = 4'd3;
   localparam logic [3:0] SLOT_C2 = 4'd4;
   localparam logic [3:0] SLOT_C3 = 4'd5;
   localparam logic [3:0] SLOT_T0 = 4'd6;
   localparam logic [3:0] SLOT_T1 = 4'd7;
   localparam logic [3:0] SLOT_T2 = 4'd8;
   localparam logic [3:0] SLOT_T3 = 4'd9;
   localparam logic [3:0] SLOT_T4 = 4'd10;
   localparam logic [3:0] SLOT_T5 = 4'd11;
   localparam logic [3:0] SLOT_T6 = 4'd12;
   localparam logic [3:0] SLOT_T7 = 4'd13;
   localparam logic [3:0] SLOT_T8 = 4'd14;
   localparam logic [3:0] SLOT_T9 = 4'd15;

   typedef struct packed {
      kcv_op_type op;
      logic [4:0] src_a;
      logic [4:0] src_b;
      logic [3:0] dst;
   } kcv_instr_type;

   localparam logic [4:0] PROG_LAST = 5'd26;

   // One predict and update step of one axis.
   function automatic kcv_instr_type kcv_prog(input logic [4:0] pc);
      kcv_instr_type i;
      case (pc)
         5'd0:  i = '{OP_MUL, SRC_A,    SRC_V,  SLOT_T0};
         5'd1:  i = '{OP_ADD, SRC_P,    SRC_T0, SLOT_T1};
         5'd2:  i = '{OP_MUL, SRC_A,    SRC_C2, SLOT_T0};
         5'd3:  i = '{OP_ADD, SRC_C0,   SRC_T0, SLOT_T2};
         5'd4:  i = '{OP_MUL, SRC_A,    SRC_C3, SLOT_T0};
         5'd5:  i = '{OP_ADD, SRC_C1,   SRC_T0, SLOT_T3};
         5'd6:  i = '{OP_MUL, SRC_A,    SRC_T3, SLOT_T0};
         5'd7:  i = '{OP_ADD, SRC_T2,   SRC_T0, SLOT_T2};
         5'd8:  i = '{OP_ADD, SRC_T2,   SRC_Q,  SLOT_T2};
         5'd9:  i = '{OP_MUL, SRC_A,    SRC_C3, SLOT_T0};
         5'd10: i = '{OP_ADD, SRC_C2,   SRC_T0, SLOT_T4};
         5'd11: i = '{OP_ADD, SRC_C3,   SRC_Q,  SLOT_T5};
         5'd12: i = '{OP_ADD, SRC_T2,   SRC_R,  SLOT_T6};
         5'd13: i = '{OP_DIV, SRC_T2,   SRC_T6, SLOT_T7};
         5'd14: i = '{OP_DIV, SRC_T4,   SRC_T6, SLOT_T8};
         5'd15: i = '{OP_SUB, SRC_MEAS, SRC_T1, SLOT_T9};
         5'd16: i = '{OP_MUL, SRC_T7,   SRC_T9, SLOT_T0};
         5'd17: i = '{OP_ADD, SRC_T1,   SRC_T0, SLOT_P};
         5'd18: i = '{OP_MUL, SRC_T8,   SRC_T9, SLOT_T0};
         5'd19: i = '{OP_ADD, SRC_V,    SRC_T0, SLOT_V};
         5'd20: i = '{OP_SUB, SRC_ONE,  SRC_T7, SLOT_T6};
         5'd21: i = '{OP_MUL, SRC_T6,   SRC_T2, SLOT_C0};
         5'd22: i = '{OP_MUL, SRC_T6,   SRC_T3, SLOT_C1};
         5'd23: i = '{OP_MUL, SRC_T8,   SRC_T2, SLOT_T0};
         5'd24: i = '{OP_SUB, SRC_T4,   SRC_T0, SLOT_C2};
         5'd25: i = '{OP_MUL, SRC_T8,   SRC_T3, SLOT_T0};
         5'd26: i = '{OP_SUB, SRC_T5,   SRC_T0, SLOT_C3};
         default: i = '{OP_ADD, SRC_T0, SRC_T0, SLOT_T0};
      endcase
      return i;
   endfunction

   // Applies a sign to a magnitude and saturates to the 48-bit range.
   function automatic logic signed [47:0] kcv_sat_mag(input logic neg,
                                                      input logic [71:0] m);
      logic signed [47:0] r;
      if (neg) begin
         if (m > 72'h800000000000) r = {1'b1, 47'b0};
         else r = -$signed(m[47:0]);
      end else begin
         if (m > 72'h7FFFFFFFFFFF) r = {1'b0, {47{1'b1}}};
         else r = $signed(m[47:0]);
      end
      return r;
   endfunction

   // Whole pixels, truncated toward zero and saturated to 16 bits.
   function automatic logic signed [15:0] kcv_to_pixel(input logic signed [47:0] v);
      logic [47:0] m;
      logic [23:0] w;
      logic signed [15:0] r;
      m = v[47] ? 48'(-v) : 48'(v);
      w = m[47:24];
      if (v[47]) begin
         if (w > 24'd32768) r = 16'sh8000;
         else r = 16'(-w);
      end else begin
         if (w > 24'd32767) r = 16'sh7FFF;
         else r = 16'(w);
      end
      return r;
   endfunction

endpackage

### design/kcv_regfile.sv
// ----------------------------------------------------------------------------
// Kalman tracker register file
// Holds state and scratch values of both axes; two registered reads.
// ----------------------------------------------------------------------------
module kcv_regfile import kcv_pkg::*; (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [4:0]         wr_addr,
   input  logic signed [47:0] wr_data,
   input  logic [4:0]         rd_addr_a,
   input  logic [4:0]         rd_addr_b,
   output logic signed [47:0] rd_data_a,
   output logic signed [47:0] rd_data_b
);

   logic signed [47:0] mem [32];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

### design/kcv_alu.sv
// ----------------------------------------------------------------------------
// Kalman tracker arithmetic unit
// Saturating Q24.24 add, subtract, multiply and divide, one op at a time.
// ----------------------------------------------------------------------------
module kcv_alu import kcv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  kcv_alu_cmd_type    cmd,
   output logic               done,
   output logic signed [47:0] result
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_DIV  = 5'b00100,
      S_FIN  = 5'b01000,
      S_DONE = 5'b10000
   } alu_state_type;

   alu_state_type      state_ff, state_in;
   logic [6:0]         cnt_ff, cnt_in;
   kcv_op_type         op_ff, op_in;
   logic               neg_ff, neg_in;
   logic [47:0]        ua_ff, ua_in, ub_ff, ub_in;
   logic [47:0]        prod_ff, prod_in;
   logic [1:0]         pidx_ff, pidx_in;
   logic [95:0]        acc_ff, acc_in;
   logic [71:0]        num_ff, num_in, q_ff, q_in;
   logic [47:0]        rem_ff, rem_in;
   logic signed [47:0] result_ff, result_in;
   logic [48:0]        rem_sh;
   logic               rem_ge;

   function automatic logic [47:0] mag(input logic signed [47:0] v);
      return v[47] ? 48'(-v) : 48'(v);
   endfunction

   function automatic logic signed [47:0] sat49(input logic signed [48:0] s);
      logic signed [47:0] r;
      if (s[48] != s[47]) r = s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
      else r = s[47:0];
      return r;
   endfunction

   function automatic logic [95:0] place(input logic [47:0] p, input logic [1:0] idx);
      logic [95:0] r;
      case (idx)
         2'b00:   r = {48'b0, p};
         2'b11:   r = {p, 48'b0};
         default: r = {24'b0, p, 24'b0};
      endcase
      return r;
   endfunction

   // One restoring division step per cycle over the 72-bit scaled dividend.
   assign rem_sh = {rem_ff, num_ff[71]};
   assign rem_ge = rem_sh >= {1'b0, ub_ff};

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      op_in     = op_ff;
      neg_in    = neg_ff;
      ua_in     = ua_ff;
      ub_in     = ub_ff;
      prod_in   = prod_ff;
      pidx_in   = pidx_ff;
      acc_in    = acc_ff;
      num_in    = num_ff;
      q_in      = q_ff;
      rem_in    = rem_ff;
      result_in = result_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               op_in  = cmd.op;
               neg_in = cmd.a[47] ^ cmd.b[47];
               ua_in  = mag(cmd.a);
               ub_in  = mag(cmd.b);
               cnt_in = '0;
               acc_in = '0;
               q_in   = '0;
               rem_in = '0;
               num_in = {mag(cmd.a), 24'b0};
               case (cmd.op)
                  OP_ADD: begin
                     result_in = sat49(49'(cmd.a) + 49'(cmd.b));
                     state_in  = S_DONE;
                  end
                  OP_SUB: begin
                     result_in = sat49(49'(cmd.a) - 49'(cmd.b));
                     state_in  = S_DONE;
                  end
                  OP_MUL: begin
                     state_in = S_MUL;
                  end
                  OP_DIV: begin
                     // A zero divisor gives a zero gain.
                     if (cmd.b == '0) begin
                        result_in = '0;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_DIV;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_MUL: begin
            // 24x24 partial products, each added in the cycle after it is formed.
            prod_in = 48'((cnt_ff[1] ? ua_ff[47:24] : ua_ff[23:0]) *
                          (cnt_ff[0] ? ub_ff[47:24] : ub_ff[23:0]));
            pidx_in = cnt_ff[1:0];
            if (cnt_ff != '0) begin
               acc_in = acc_ff + place(prod_ff, pidx_ff);
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd4) begin
               state_in = S_FIN;
            end
         end
         S_DIV: begin
            rem_in = rem_ge ? 48'(rem_sh - {1'b0, ub_ff}) : rem_sh[47:0];
            q_in   = {q_ff[70:0], rem_ge};
            num_in = {num_ff[70:0], 1'b0};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd71) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            result_in = kcv_sat_mag(neg_ff, (op_ff == OP_MUL) ? acc_ff[95:24] : q_ff);
            state_in  = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      neg_ff    <= neg_in;
      ua_ff     <= ua_in;
      ub_ff     <= ub_in;
      prod_ff   <= prod_in;
      pidx_ff   <= pidx_in;
      acc_ff    <= acc_in;
      num_ff    <= num_in;
      q_ff      <= q_in;
      rem_ff    <= rem_in;
      result_ff <= result_in;
   end

   assign done   = (state_ff == S_DONE);
   assign result = result_ff;

endmodule

### design/kalman_cv_tracker_2d_core.sv
// ----------------------------------------------------------------------------
// Two-axis constant-velocity Kalman tracker
// Sequencer, configuration registers and result register around one shared
// fixed-point arithmetic unit.
// ----------------------------------------------------------------------------
// A measured point arrives as one word on req_ (valid/ready) and yields one
// word on rsp_ with the filtered x and y positions in whole pixels.
// The csr_ port writes the five configuration registers by index; it is
// always ready and is meant to be used while the tracker is idle. Writing a
// start position reloads that axis's position at once.
// Each point runs a 27-instruction program per axis, x then y, through one
// arithmetic unit. The two 72-step divisions per axis take about half of
// a point's time from acceptance to the result.
// A zero innovation variance skips the divide iterations.
// req_ready is high only between points. The result sits in an output
// register, so the next point is accepted while it waits; if the receiver
// still stalls when the next result is ready, the sequencer holds there.
// Reset loads the default registers, clears velocity and covariance and sets
// the positions to the start values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module kalman_cv_tracker_2d_core import kcv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  kcv_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output kcv_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_LOAD  = 5'b00100,
      ST_RUN   = 5'b01000,
      ST_DONE  = 5'b10000
   } seq_state_type;

   seq_state_type      state_ff, state_in;
   logic [4:0]         pc_ff, pc_in;
   logic               axis_ff, axis_in;
   logic [31:0]        valid_ff, valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   kcv_rsp_type        rsp_data_ff, rsp_data_in;
   kcv_rsp_type        est_ff, est_in;
   kcv_req_type        meas_ff, meas_in;
   logic [31:0]        step_coeff_ff;
   logic [23:0]        process_noise_ff;
   logic [31:0]        measure_noise_ff;
   logic signed [15:0] start_x_ff, start_y_ff;

   kcv_instr_type      instr;
   kcv_alu_cmd_type    alu_cmd;
   logic               alu_done;
   logic signed [47:0] alu_result;
   logic               wr_en;
   logic [4:0]         wr_addr, rd_addr_a, rd_addr_b;
   logic signed [47:0] rd_data_a, rd_data_b;
   logic signed [15:0] start_cur, meas_cur;
   logic               csr_fire;

   function automatic logic signed [47:0] q24(input logic signed [15:0] v);
      return {{8{v[15]}}, v, 24'b0};
   endfunction

   // Constants and the measurement come from registers; a slot never written
   // since reset or a start write reads as its reset value.
   function automatic logic signed [47:0] operand(
      input logic [4:0]         code,
      input logic signed [47:0] rdata,
      input logic               vld,
      input logic signed [15:0] start,
      input logic signed [15:0] meas,
      input logic [31:0]        a,
      input logic [23:0]        q,
      input logic [31:0]        r
   );
      logic signed [47:0] v;
      case (code)
         SRC_A:    v = {16'b0, a};
         SRC_Q:    v = {24'b0, q};
         SRC_R:    v = {16'b0, r};
         SRC_ONE:  v = 48'sh000001000000;
         SRC_MEAS: v = q24(meas);
         default: begin
            if (code[4]) v = '0;
            else if (vld) v = rdata;
            else if (code[3:0] == SLOT_P) v = q24(start);
            else v = '0;
         end
      endcase
      return v;
   endfunction

   assign instr     = kcv_prog(pc_ff);
   assign rd_addr_a = {axis_ff, instr.src_a[3:0]};
   assign rd_addr_b = {axis_ff, instr.src_b[3:0]};
   assign wr_addr   = {axis_ff, instr.dst};
   assign wr_en     = (state_ff == ST_RUN) && alu_done;
   assign start_cur = axis_ff ? start_y_ff : start_x_ff;
   assign meas_cur  = axis_ff ? meas_ff.meas_y : meas_ff.meas_x;
   assign csr_fire  = csr_valid && csr_ready;

   always_comb begin
      alu_cmd.start = (state_ff == ST_LOAD);
      alu_cmd.op    = instr.op;
      alu_cmd.a     = operand(instr.src_a, rd_data_a, valid_ff[rd_addr_a], start_cur,
                              meas_cur, step_coeff_ff, process_noise_ff,
                              measure_noise_ff);
      alu_cmd.b     = operand(instr.src_b, rd_data_b, valid_ff[rd_addr_b], start_cur,
                              meas_cur, step_coeff_ff, process_noise_ff,
                              measure_noise_ff);
   end

   kcv_regfile u_regfile (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (alu_result),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   kcv_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .done   (alu_done),
      .result (alu_result)
   );

   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      axis_in      = axis_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      est_in       = est_ff;
      meas_in      = meas_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
         if (instr.dst == SLOT_P) begin
            if (axis_ff) est_in.est_y = kcv_to_pixel(alu_result);
            else est_in.est_x = kcv_to_pixel(alu_result);
         end
      end

      if (csr_fire && (csr_index == REG_START_X)) begin
         valid_in[{1'b0, SLOT_P}] = 1'b0;
      end
      if (csr_fire && (csr_index == REG_START_Y)) begin
         valid_in[{1'b1, SLOT_P}] = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               meas_in  = req_data;
               pc_in    = '0;
               axis_in  = 1'b0;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_RUN;
         ST_RUN: begin
            if (alu_done) begin
               if (pc_ff == PROG_LAST) begin
                  pc_in = '0;
                  if (axis_ff) begin
                     state_in = ST_DONE;
                  end else begin
                     axis_in  = 1'b1;
                     state_in = ST_FETCH;
                  end
               end else begin
                  pc_in    = pc_ff + 5'd1;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = est_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         axis_ff      <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         axis_ff      <= axis_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      est_ff      <= est_in;
      meas_ff     <= meas_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_coeff_ff    <= 32'd9227469;
         process_noise_ff <= 24'd1678;
         measure_noise_ff <= 32'd167772;
         start_x_ff       <= 16'sd200;
         start_y_ff       <= 16'sd150;
      end else if (csr_fire) begin
         case (csr_index)
            REG_STEP_COEFF:    step_coeff_ff    <= csr_wdata;
            REG_PROCESS_NOISE: process_noise_ff <= csr_wdata[23:0];
            REG_MEASURE_NOISE: measure_noise_ff <= csr_wdata;
            REG_START_X:       start_x_ff       <= csr_wdata[15:0];
            REG_START_Y:       start_y_ff       <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

### design/kcv_checker.sv
// ----------------------------------------------------------------------------
// Kalman tracker port checker
// Watches the top-level ports over time; bound to the tracker core.
// ----------------------------------------------------------------------------
`include "kalman_cv_tracker_2d_core_defines.svh"

module kcv_checker import kcv_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input kcv_rsp_type rsp_data
);

   // A held result word keeps its value until taken.
   `KCV_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // After taking a word the tracker is busy for the filter run.
   `KCV_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

   // A word taken cannot produce its result in the very next cycle.
   `KCV_ASSERT_NEXT(a_no_instant_rsp, req_valid && req_ready && !rsp_valid,
                    !rsp_valid)

   // Reset leaves the tracker idle with no result pending.
   `KCV_ASSERT_NEXT_ALWAYS(a_reset_idle, reset, req_ready && !rsp_valid)

endmodule

bind kalman_cv_tracker_2d_core kcv_checker u_kcv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
